### rtl/clnw_pkg.sv
`timescale 1ns / 1ps

package clnw_pkg;

	localparam int MAX_DIGITS  = 16;
	localparam int SIGNED_CAP  = 15;
	localparam int BCD_DIGITS  = 5;
	localparam int VALUE_W     = 16;
	localparam int CONV_STEPS  = VALUE_W;

	localparam logic [2:0] ACT_INIT = 3'd0;
	localparam logic [2:0] ACT_CHAR = 3'd1;
	localparam logic [2:0] ACT_UDEC = 3'd2;
	localparam logic [2:0] ACT_SDEC = 3'd3;
	localparam logic [2:0] ACT_HEX  = 3'd4;
	localparam logic [2:0] ACT_BIN  = 3'd5;

	localparam logic [7:0] CMD_SET_ADDR = 8'h80;
	localparam logic [7:0] CMD_ENTRY    = 8'h06;
	localparam logic [7:0] CMD_DISP_ON  = 8'h0c;
	localparam logic [7:0] CMD_FUNC_SET = 8'h38;
	localparam logic [7:0] LINE2_OFFSET = 8'h40;
	localparam logic [7:0] CHR_ZERO     = 8'h30;
	localparam logic [7:0] CHR_A        = 8'h41;
	localparam logic [7:0] CHR_MINUS    = 8'h2d;
	localparam logic [7:0] CHR_PLUS     = 8'h2b;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_INIT,
		ST_POS,
		ST_SIGN,
		ST_CHAR,
		ST_DIGIT
	} state_t;

endpackage

### rtl/char_lcd_number_writer_core.sv
// Sequencing: an accepted item leaves idle, and its first byte is then loaded into the output
//   register when it is free; decimal actions first run a bit-serial binary-to-BCD conversion.
// Throughput: one byte per cycle while out_ready is high; the next item is taken the cycle
//   after the last byte of the run is loaded. An unknown action writes no byte; the longest
//   item is 16 decimal digits: conversion, position byte, then the digits.
// Reset: arst_n (async, active low) clears the sequencer and the output valid; no clear pass.
`timescale 1ns / 1ps

module char_lcd_number_writer_core (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [1:0]  row,
	input  logic [5:0]  column,
	input  logic [15:0] value,
	input  logic [4:0]  digit_count,
	// LCD write channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_data,
	output logic [7:0]  lcd_byte,
	output logic        last
);

	clnw_pkg::state_t state_q, state_nxt;

	// per-item context
	logic [2:0]  act_q;
	logic [7:0]  pos_byte_q;     // DDRAM address; the set-address bit is ORed in when emitted
	logic [4:0]  len_q;          // saturated digit count
	logic [3:0]  pos_q;          // digit position being emitted, counts down to 0
	logic [3:0]  cnt_q;          // conversion step / init command index
	logic        neg_q;
	logic [15:0] shift_q;        // magnitude being shifted out MSB first; char or binary operand
	logic [19:0] bcd_q;          // BCD digits (decimal) or hex operand in low byte

	// output register
	logic        out_valid_q;
	logic        is_data_q;
	logic [7:0]  lcd_byte_q;
	logic        last_q;

	// emit request from the sequencer
	logic        emit_valid;
	logic        emit_data;
	logic [7:0]  emit_byte;
	logic        emit_last;
	logic        slot_free;
	logic        fire;
	logic        accept;

	// accept-time decode
	logic [4:0]  len_sat;
	logic [4:0]  len_in;
	logic [7:0]  addr_in;
	logic [15:0] mag_in;

	// digit selection
	logic [3:0]  cur_nib;
	logic        cur_bit;
	logic [3:0]  cur_digit;
	logic [19:0] bcd_adj;

	assign in_ready  = (state_q == clnw_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign fire      = emit_valid && slot_free;

	assign out_valid = out_valid_q;
	assign is_data   = is_data_q;
	assign lcd_byte  = lcd_byte_q;
	assign last      = last_q;

	// digit count saturation; signed decimal leaves room for the sign
	always_comb begin
		len_sat = (digit_count > 5'(clnw_pkg::MAX_DIGITS)) ? 5'(clnw_pkg::MAX_DIGITS)
		                                                   : digit_count;
		len_in  = len_sat;
		if (action == clnw_pkg::ACT_SDEC && len_sat > 5'(clnw_pkg::SIGNED_CAP))
			len_in = 5'(clnw_pkg::SIGNED_CAP);
	end

	// DDRAM address wraps in 8 bits before the command bit is ORed in
	assign addr_in = 8'({2'b00, column}) + ((row == 2'd2) ? clnw_pkg::LINE2_OFFSET : 8'h00)
	                 - 8'd1;

	// two's complement magnitude; 0x8000 stays 32768
	assign mag_in = (action == clnw_pkg::ACT_SDEC && value[15]) ? (16'd0 - value) : value;

	// double-dabble: add 3 to every digit >= 5 before the shift
	always_comb begin
		for (int i = 0; i < clnw_pkg::BCD_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
			                                              : bcd_q[4*i +: 4];
		end
	end

	// positions above the operand's digits read as zero
	always_comb begin
		cur_nib = 4'd0;
		for (int i = 0; i < clnw_pkg::BCD_DIGITS; i++) begin
			if (pos_q == 4'(i))
				cur_nib = bcd_q[4*i +: 4];
		end
		cur_bit = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (pos_q == 4'(i))
				cur_bit = shift_q[i];
		end
		cur_digit = (act_q == clnw_pkg::ACT_BIN) ? {3'b000, cur_bit} : cur_nib;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			clnw_pkg::ST_IDLE: begin
				if (accept) begin
					case (action)
						clnw_pkg::ACT_INIT: state_nxt = clnw_pkg::ST_INIT;
						clnw_pkg::ACT_CHAR,
						clnw_pkg::ACT_HEX,
						clnw_pkg::ACT_BIN:  state_nxt = clnw_pkg::ST_POS;
						clnw_pkg::ACT_UDEC,
						clnw_pkg::ACT_SDEC: state_nxt = clnw_pkg::ST_CONV;
						default:            state_nxt = clnw_pkg::ST_IDLE; // no output
					endcase
				end
			end
			clnw_pkg::ST_CONV: begin
				if (cnt_q == 4'(clnw_pkg::CONV_STEPS - 1))
					state_nxt = clnw_pkg::ST_POS;
			end
			clnw_pkg::ST_INIT: begin
				if (fire && cnt_q == 4'd2)
					state_nxt = clnw_pkg::ST_IDLE;
			end
			clnw_pkg::ST_POS: begin
				if (fire) begin
					if (act_q == clnw_pkg::ACT_CHAR)
						state_nxt = clnw_pkg::ST_CHAR;
					else if (act_q == clnw_pkg::ACT_SDEC)
						state_nxt = clnw_pkg::ST_SIGN;
					else if (len_q == 5'd0)
						state_nxt = clnw_pkg::ST_IDLE;
					else
						state_nxt = clnw_pkg::ST_DIGIT;
				end
			end
			clnw_pkg::ST_SIGN: begin
				if (fire)
					state_nxt = (len_q == 5'd0) ? clnw_pkg::ST_IDLE : clnw_pkg::ST_DIGIT;
			end
			clnw_pkg::ST_CHAR: begin
				if (fire)
					state_nxt = clnw_pkg::ST_IDLE;
			end
			clnw_pkg::ST_DIGIT: begin
				if (fire && pos_q == 4'd0)
					state_nxt = clnw_pkg::ST_IDLE;
			end
			default: state_nxt = clnw_pkg::ST_IDLE;
		endcase
	end

	// byte to emit in the current state
	always_comb begin
		emit_valid = 1'b0;
		emit_data  = 1'b0;
		emit_byte  = 8'h00;
		emit_last  = 1'b0;
		case (state_q)
			clnw_pkg::ST_INIT: begin
				emit_valid = 1'b1;
				case (cnt_q)
					4'd0:    emit_byte = clnw_pkg::CMD_ENTRY;
					4'd1:    emit_byte = clnw_pkg::CMD_DISP_ON;
					default: emit_byte = clnw_pkg::CMD_FUNC_SET;
				endcase
				emit_last = (cnt_q == 4'd2);
			end
			clnw_pkg::ST_POS: begin
				emit_valid = 1'b1;
				emit_byte  = clnw_pkg::CMD_SET_ADDR | pos_byte_q;
				emit_last  = (len_q == 5'd0) && (act_q != clnw_pkg::ACT_CHAR)
				             && (act_q != clnw_pkg::ACT_SDEC);
			end
			clnw_pkg::ST_SIGN: begin
				emit_valid = 1'b1;
				emit_data  = 1'b1;
				emit_byte  = neg_q ? clnw_pkg::CHR_MINUS : clnw_pkg::CHR_PLUS;
				emit_last  = (len_q == 5'd0);
			end
			clnw_pkg::ST_CHAR: begin
				emit_valid = 1'b1;
				emit_data  = 1'b1;
				emit_byte  = shift_q[7:0];
				emit_last  = 1'b1;
			end
			clnw_pkg::ST_DIGIT: begin
				emit_valid = 1'b1;
				emit_data  = 1'b1;
				emit_byte  = (cur_digit >= 4'd10)
				             ? clnw_pkg::CHR_A + 8'({4'b0000, cur_digit}) - 8'd10
				             : clnw_pkg::CHR_ZERO + 8'({4'b0000, cur_digit});
				emit_last  = (pos_q == 4'd0);
			end
			default: begin
				emit_valid = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= clnw_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= 4'd0;
		end else begin
			state_q <= state_nxt;
			if (slot_free)
				out_valid_q <= emit_valid;
			if (accept)
				cnt_q <= 4'd0;
			else if (state_q == clnw_pkg::ST_CONV)
				cnt_q <= cnt_q + 4'd1;
			else if (state_q == clnw_pkg::ST_INIT && fire)
				cnt_q <= cnt_q + 4'd1;
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (fire) begin
			is_data_q  <= emit_data;
			lcd_byte_q <= emit_byte;
			last_q     <= emit_last;
		end
		if (accept) begin
			act_q      <= action;
			pos_byte_q <= addr_in;
			len_q      <= len_in;
			neg_q      <= value[15];
			shift_q    <= mag_in;
			bcd_q      <= (action == clnw_pkg::ACT_HEX) ? {12'h000, value[7:0]} : 20'h00000;
		end else if (state_q == clnw_pkg::ST_CONV) begin
			// one bit of the magnitude enters the BCD register per cycle
			bcd_q   <= {bcd_adj[18:0], shift_q[15]};
			shift_q <= {shift_q[14:0], 1'b0};
		end
		// leaving the position or sign byte: start at the most significant digit
		if (fire && (state_q == clnw_pkg::ST_POS || state_q == clnw_pkg::ST_SIGN))
			pos_q <= 4'(len_q - 5'd1);
		else if (fire && state_q == clnw_pkg::ST_DIGIT)
			pos_q <= pos_q - 4'd1;
	end

endmodule

### tb/char_lcd_number_writer_core_tb.sv
`timescale 1ns / 1ps

module char_lcd_number_writer_core_tb;

	// Abort when neither channel has moved an item for this many cycles.
	// The slowest item is a full decimal run plus receiver stalls
	// on up to 17 writes, so this leaves a wide margin.
	localparam int unsigned QUIET_LIMIT = 4000;
	// Covers the longest run of an item inside the block, used for the settle at the end.
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned ITEMS_PER_PHASE = 115;

	// One bus write as the block presents it.
	typedef struct packed {
		logic       is_data;
		logic [7:0] lcd_byte;
		logic       last;
	} lcd_write_t;

	// Turns each accepted request into the LCD writes it must produce and
	// checks the writes the block presents, in order.
	class lcd_write_checker;
		lcd_write_t  pending_writes[$];
		int unsigned errors;

		function new();
			errors = 0;
		endfunction

		function int unsigned outstanding();
			return pending_writes.size();
		endfunction

		function void add_write(logic d, logic [7:0] b);
			lcd_write_t w;
			w.is_data  = d;
			w.lcd_byte = b;
			w.last     = 1'b0;
			pending_writes.push_back(w);
		endfunction

		// Low 'len' decimal digits of mag, most significant first, zero padded.
		function void add_decimal(longint unsigned mag, int unsigned len);
			longint unsigned base;
			for (int unsigned i = 0; i < len; i++) begin
				base = 1;
				for (int unsigned k = 0; k + 1 + i < len; k++)
					base *= 10;
				add_write(1'b1, clnw_pkg::CHR_ZERO + 8'((mag / base) % 10));
			end
		endfunction

		function void note_request(logic [2:0] act, logic [1:0] r, logic [5:0] col,
				logic [15:0] val, logic [4:0] cnt);
			int unsigned first;
			int unsigned len;
			int unsigned pos;
			logic [7:0]  addr;
			logic [7:0]  operand;
			logic [3:0]  nib;
			logic [16:0] mag;

			first   = pending_writes.size();
			len     = (cnt > clnw_pkg::MAX_DIGITS) ? clnw_pkg::MAX_DIGITS : cnt;
			operand = val[7:0];
			// address wraps in 8 bits, so column 0 on a first-line row gives 0xff
			addr    = ((r == 2'd2) ? clnw_pkg::LINE2_OFFSET : 8'h00) + {2'b00, col} - 8'd1;

			case (act)
				clnw_pkg::ACT_INIT: begin
					add_write(1'b0, clnw_pkg::CMD_ENTRY);
					add_write(1'b0, clnw_pkg::CMD_DISP_ON);
					add_write(1'b0, clnw_pkg::CMD_FUNC_SET);
				end
				clnw_pkg::ACT_CHAR: begin
					add_write(1'b0, clnw_pkg::CMD_SET_ADDR | addr);
					add_write(1'b1, operand);
				end
				clnw_pkg::ACT_UDEC: begin
					add_write(1'b0, clnw_pkg::CMD_SET_ADDR | addr);
					add_decimal(val, len);
				end
				clnw_pkg::ACT_SDEC: begin
					add_write(1'b0, clnw_pkg::CMD_SET_ADDR | addr);
					if (len > clnw_pkg::SIGNED_CAP)
						len = clnw_pkg::SIGNED_CAP;
					if (val[15]) begin
						add_write(1'b1, clnw_pkg::CHR_MINUS);
						mag = 17'h10000 - {1'b0, val};
					end else begin
						add_write(1'b1, clnw_pkg::CHR_PLUS);
						mag = {1'b0, val};
					end
					add_decimal(mag, len);
				end
				clnw_pkg::ACT_HEX: begin
					add_write(1'b0, clnw_pkg::CMD_SET_ADDR | addr);
					for (int unsigned i = 0; i < len; i++) begin
						pos = len - 1 - i;
						nib = (pos < 2) ? operand[4*pos +: 4] : 4'h0;
						add_write(1'b1, (nib >= 4'd10) ? clnw_pkg::CHR_A + 8'(nib - 4'd10)
							: clnw_pkg::CHR_ZERO + 8'(nib));
					end
				end
				clnw_pkg::ACT_BIN: begin
					add_write(1'b0, clnw_pkg::CMD_SET_ADDR | addr);
					for (int unsigned i = 0; i < len; i++) begin
						pos = len - 1 - i;
						add_write(1'b1,
							clnw_pkg::CHR_ZERO + 8'((pos < 8) ? operand[pos] : 1'b0));
					end
				end
				default: ;	// unknown actions write nothing
			endcase

			if (pending_writes.size() > first)
				pending_writes[pending_writes.size() - 1].last = 1'b1;
		endfunction

		function void check_write(logic d, logic [7:0] b, logic l);
			lcd_write_t want;
			if (pending_writes.size() == 0) begin
				$error("unexpected write: is_data=%0b lcd_byte=%02h last=%0b", d, b, l);
				errors++;
				return;
			end
			want = pending_writes.pop_front();
			if (d !== want.is_data) begin
				$error("is_data: expected %0b, actual %0b", want.is_data, d);
				errors++;
			end
			if (b !== want.lcd_byte) begin
				$error("lcd_byte: expected %02h, actual %02h", want.lcd_byte, b);
				errors++;
			end
			if (l !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, l);
				errors++;
			end
		endfunction

		function void check_drained();
			if (pending_writes.size() != 0) begin
				$error("%0d expected writes never arrived", pending_writes.size());
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  action;
	logic [1:0]  row;
	logic [5:0]  column;
	logic [15:0] value;
	logic [4:0]  digit_count;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        is_data;
	logic [7:0]  lcd_byte;
	logic        last;

	// Idle rates in percent, changed per phase by the stimulus.
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned quiet_cycles = 0;

	lcd_write_checker board;

	char_lcd_number_writer_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.row        (row),
		.column     (column),
		.value      (value),
		.digit_count(digit_count),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.is_data    (is_data),
		.lcd_byte   (lcd_byte),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: out_ready drops at random according to the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Both channels are sampled at the edge, so handshakes see pre-edge values
	// regardless of process order.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			board.note_request(action, row, column, value, digit_count);
		if (out_valid && out_ready)
			board.check_write(is_data, lcd_byte, last);
	end

	// Watchdog: counts cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("char_lcd_number_writer_core_tb: FAIL");
			$finish;
		end
	end

	// Called at the edge where the previous item was taken (or at start).
	// A zero gap keeps in_valid high and only swaps the payload.
	task automatic send_request(logic [2:0] act, logic [1:0] r, logic [5:0] col,
			logic [15:0] val, logic [4:0] cnt);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		row         <= r;
		column      <= col;
		value       <= val;
		digit_count <= cnt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Hold off the sender until every expected write has come back.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (board.outstanding() != 0);
	endtask

	task automatic send_random_request();
		logic [2:0]  act;
		logic [1:0]  r;
		logic [5:0]  col;
		logic [15:0] val;
		logic [4:0]  cnt;
		// mostly valid actions; a few unknown ones
		act = ($urandom_range(99) < 5) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
		r   = 2'($urandom);
		col = ($urandom_range(99) < 85) ? 6'($urandom_range(40, 1)) : 6'($urandom);
		cnt = ($urandom_range(99) < 85) ? 5'($urandom_range(16, 1)) : 5'($urandom);
		case ($urandom_range(9))
			0:       val = 16'h8000;
			1:       val = 16'hffff;
			2:       val = 16'h7fff;
			3:       val = 16'h0000;
			default: val = 16'($urandom);
		endcase
		send_request(act, r, col, val, cnt);
	endtask

	initial begin
		board       = new();
		tx_idle_pct = 19;
		rx_idle_pct = 52;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		action      = clnw_pkg::ACT_INIT;
		row         = 2'd1;
		column      = 6'd1;
		value       = 16'h0000;
		digit_count = 5'd1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: every action, field extremes, wrap and saturation cases.
		send_request(clnw_pkg::ACT_INIT, 2'd0, 6'd0, 16'hffff, 5'd31);
		send_request(clnw_pkg::ACT_CHAR, 2'd2, 6'd40, 16'hff41, 5'd1);
		send_request(clnw_pkg::ACT_CHAR, 2'd1, 6'd1, 16'h00ff, 5'd0);
		// column 0 wraps the address to 0xff
		send_request(clnw_pkg::ACT_CHAR, 2'd1, 6'd0, 16'h0000, 5'd1);
		// rows 0 and 3 both select the first line
		send_request(clnw_pkg::ACT_CHAR, 2'd3, 6'd63, 16'h5a5a, 5'd1);
		send_request(clnw_pkg::ACT_CHAR, 2'd0, 6'd20, 16'ha5a5, 5'd1);
		send_request(clnw_pkg::ACT_UDEC, 2'd2, 6'd1, 16'hffff, 5'd16);
		send_request(clnw_pkg::ACT_UDEC, 2'd1, 6'd5, 16'd12345, 5'd3);
		send_request(clnw_pkg::ACT_UDEC, 2'd1, 6'd1, 16'd0, 5'd1);
		send_request(clnw_pkg::ACT_UDEC, 2'd2, 6'd9, 16'd999, 5'd0);
		send_request(clnw_pkg::ACT_UDEC, 2'd2, 6'd9, 16'd54321, 5'd31);
		// most negative value keeps its magnitude; count capped to 15
		send_request(clnw_pkg::ACT_SDEC, 2'd1, 6'd1, 16'h8000, 5'd16);
		send_request(clnw_pkg::ACT_SDEC, 2'd2, 6'd3, 16'h7fff, 5'd5);
		send_request(clnw_pkg::ACT_SDEC, 2'd1, 6'd7, 16'hffff, 5'd1);
		send_request(clnw_pkg::ACT_SDEC, 2'd1, 6'd7, 16'hfffe, 5'd0);
		send_request(clnw_pkg::ACT_SDEC, 2'd2, 6'd40, 16'h0000, 5'd20);
		send_request(clnw_pkg::ACT_HEX, 2'd1, 6'd1, 16'h12ab, 5'd2);
		send_request(clnw_pkg::ACT_HEX, 2'd2, 6'd2, 16'h01f5, 5'd4);
		send_request(clnw_pkg::ACT_HEX, 2'd1, 6'd3, 16'hffff, 5'd17);
		send_request(clnw_pkg::ACT_HEX, 2'd1, 6'd3, 16'h00c0, 5'd0);
		send_request(clnw_pkg::ACT_BIN, 2'd2, 6'd1, 16'h00a5, 5'd8);
		send_request(clnw_pkg::ACT_BIN, 2'd1, 6'd30, 16'hff5a, 5'd10);
		send_request(clnw_pkg::ACT_BIN, 2'd1, 6'd30, 16'h0001, 5'd31);
		// unknown actions write nothing
		send_request(3'd6, 2'd1, 6'd1, 16'h1234, 5'd4);
		send_request(3'd7, 2'd2, 6'd2, 16'hffff, 5'd16);
		wait_for_drain();

		// Random phases: sender-light, receiver-light, then no idling at all.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin tx_idle_pct = 19; rx_idle_pct = 52; end
				1: begin tx_idle_pct = 52; rx_idle_pct = 19; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			repeat (ITEMS_PER_PHASE) begin
				send_random_request();
				if ($urandom_range(99) < 2)
					wait_for_drain();
			end
			wait_for_drain();
		end

		// Let any stray writes surface before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		board.check_drained();
		if (board.errors == 0)
			$display("char_lcd_number_writer_core_tb: PASS");
		else
			$display("char_lcd_number_writer_core_tb: FAIL");
		$finish;
	end

endmodule
